// File: src/lfb_pkg.sv
// Shared types and constants for the latest-frame two-slot buffer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lfb_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 1048576;
    localparam int unsigned HEADER_BYTES    = 64;
    localparam int unsigned PAD_BLOCK_BYTES = 16384;  // power of two
    localparam int unsigned MIN_FRAME_BYTES = 4;

    localparam int LEN_W   = 21;
    localparam int SEQ_W   = 32;
    localparam int STAMP_W = 64;
    localparam int SUM_W   = LEN_W + 1;
    localparam int DATA_W  = 120;

    localparam logic [SUM_W-1:0] HDR_SUM   = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] PAD_ROUND = SUM_W'(PAD_BLOCK_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(MIN_FRAME_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME_BYTES);

    typedef enum logic [2:0] {
        FN_OPEN    = 3'd0,
        FN_CLOSE   = 3'd1,
        FN_BEGIN   = 3'd2,
        FN_COMMIT  = 3'd3,
        FN_TAKE    = 3'd4,
        FN_RELEASE = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        PH_FREE    = 2'd0,
        PH_WRITING = 2'd1,
        PH_PENDING = 2'd2,
        PH_SENDING = 2'd3
    } phase_t;

    // controller to datapath
    typedef struct packed {
        logic load;  // capture the input word
        logic exec;  // run the captured command, update slots and result
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: src/lfb_ctrl.sv
// Handshake controller for the latest-frame two-slot buffer.
// Depends on lfb_pkg; drives dp_cmd_t into lfb_datapath.
`default_nettype none

module lfb_ctrl
    import lfb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign cmd.load = s_tready && s_tvalid;
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

`default_nettype wire

// File: src/lfb_datapath.sv
// Slot state, header fields and result registers of the two-slot buffer.
// Depends on lfb_pkg; sequenced by lfb_ctrl through dp_cmd_t.
`default_nettype none

module lfb_datapath
    import lfb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    input  wire logic [2:0]         in_func,
    input  wire logic [LEN_W-1:0]   in_length,
    input  wire logic [SEQ_W-1:0]   in_seq,
    input  wire logic [STAMP_W-1:0] in_stamp,
    input  wire logic               in_sel,
    output logic                    res_status,
    output logic                    res_slot,
    output logic [SEQ_W-1:0]        res_seq,
    output logic [STAMP_W-1:0]      res_stamp,
    output logic [LEN_W-1:0]        res_wire
);

    // captured command
    logic [2:0]         func_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               sel_reg;

    // slot state
    phase_t             phase_reg [2];
    phase_t             phase_next [2];
    logic               accept_reg;
    logic               accept_next;
    logic [SEQ_W-1:0]   slot_seq_reg [2];
    logic [STAMP_W-1:0] slot_stamp_reg [2];
    logic [LEN_W-1:0]   slot_len_reg [2];

    logic               wr_en;
    logic               wr_slot;
    logic               status_next;
    logic               slot_next;
    logic               take_ok;
    logic               pend0;
    logic               pend1;
    logic [SUM_W-1:0]   total;
    logic [SUM_W-1:0]   rounded;

    assign pend0 = (phase_reg[0] == PH_PENDING);
    assign pend1 = (phase_reg[1] == PH_PENDING);

    always_comb
    begin
        phase_next[0] = phase_reg[0];
        phase_next[1] = phase_reg[1];
        accept_next   = accept_reg;
        wr_en         = 1'b0;
        wr_slot       = 1'b0;
        status_next   = 1'b1;
        slot_next     = 1'b0;
        take_ok       = 1'b0;
        case (func_reg)
            FN_OPEN:
            begin
                accept_next = 1'b1;
                status_next = 1'b0;
            end
            FN_CLOSE:
            begin
                accept_next = 1'b0;
                status_next = 1'b0;
            end
            FN_BEGIN:
            begin
                if (accept_reg && length_reg >= LEN_MIN && length_reg <= LEN_MAX)
                begin
                    if (phase_reg[0] == PH_FREE)
                    begin
                        wr_en   = 1'b1;
                        wr_slot = 1'b0;
                    end
                    else if (phase_reg[1] == PH_FREE)
                    begin
                        wr_en   = 1'b1;
                        wr_slot = 1'b1;
                    end
                    else if (pend0 && pend1)
                    begin
                        wr_en   = 1'b1;
                        wr_slot = (slot_seq_reg[1] < slot_seq_reg[0]);
                    end
                    else if (pend0 || pend1)
                    begin
                        wr_en   = 1'b1;
                        wr_slot = pend1;
                    end
                end
                if (wr_en)
                begin
                    phase_next[wr_slot] = PH_WRITING;
                    status_next         = 1'b0;
                    slot_next           = wr_slot;
                end
            end
            FN_COMMIT:
            begin
                if (phase_reg[sel_reg] == PH_WRITING)
                begin
                    phase_next[sel_reg] = accept_reg ? PH_PENDING : PH_FREE;
                    status_next         = 1'b0;
                end
            end
            FN_TAKE:
            begin
                if (accept_reg && (pend0 || pend1))
                begin
                    take_ok = 1'b1;
                    if (pend0 && pend1)
                    begin
                        slot_next = (slot_seq_reg[1] > slot_seq_reg[0]);
                    end
                    else
                    begin
                        slot_next = pend1;
                    end
                    phase_next[!slot_next] = pend0 && pend1 ? PH_FREE : phase_reg[!slot_next];
                    phase_next[slot_next]  = PH_SENDING;
                    status_next            = 1'b0;
                end
            end
            FN_RELEASE:
            begin
                if (phase_reg[sel_reg] == PH_SENDING)
                begin
                    phase_next[sel_reg] = PH_FREE;
                    status_next         = 1'b0;
                end
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    // pad block is a power of two: round up by add and mask
    assign total   = {1'b0, slot_len_reg[slot_next]} + HDR_SUM;
    assign rounded = (total + PAD_ROUND) & ~PAD_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg[0] <= PH_FREE;
            phase_reg[1] <= PH_FREE;
            accept_reg   <= 1'b0;
        end
        else if (cmd.exec)
        begin
            phase_reg[0] <= phase_next[0];
            phase_reg[1] <= phase_next[1];
            accept_reg   <= accept_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_func;
            length_reg <= in_length;
            seq_reg    <= in_seq;
            stamp_reg  <= in_stamp;
            sel_reg    <= in_sel;
        end
        if (cmd.exec)
        begin
            if (wr_en)
            begin
                slot_len_reg[wr_slot]   <= length_reg;
                slot_seq_reg[wr_slot]   <= seq_reg;
                slot_stamp_reg[wr_slot] <= stamp_reg;
            end
            res_status <= status_next;
            res_slot   <= slot_next;
            res_seq    <= take_ok ? slot_seq_reg[slot_next] : '0;
            res_stamp  <= take_ok ? slot_stamp_reg[slot_next] : '0;
            res_wire   <= take_ok ? rounded[LEN_W-1:0] : '0;
        end
    end

endmodule

`default_nettype wire

// File: src/latest_frame_two_slot_buffer.sv
// Top level of the latest-frame two-slot buffer: stream ports and packing.
// Depends on lfb_pkg, lfb_ctrl and lfb_datapath.
//
// A producer reserves, commits and a consumer takes and releases frames in
// two slots; each input word is one command and returns exactly one result
// word. The cycle after a word is accepted executes the command, and the
// result is offered from the next cycle on and held until m_tready takes
// it; s_tready stays low until the result has been taken, so a new command
// is not accepted while one is in flight. Take returns the pending frame
// with the highest sequence and its length plus header, rounded up to the
// pad block.
`default_nettype none

module latest_frame_two_slot_buffer
    import lfb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // frame_length[20:0], frame_seq[52:21], frame_stamp[116:53], slot_sel[117], zero
    input  wire logic [DATA_W-1:0] s_tdata,
    // func[2:0]
    input  wire logic [2:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // slot_out[0], seq_out[32:1], stamp_out[96:33], wire_length[117:97], zero
    output logic [DATA_W-1:0]      m_tdata,
    // status[0]
    output logic [0:0]             m_tuser
);

    dp_cmd_t            cmd;
    logic               res_status;
    logic               res_slot;
    logic [SEQ_W-1:0]   res_seq;
    logic [STAMP_W-1:0] res_stamp;
    logic [LEN_W-1:0]   res_wire;

    lfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lfb_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_func    (s_tuser),
        .in_length  (s_tdata[20:0]),
        .in_seq     (s_tdata[52:21]),
        .in_stamp   (s_tdata[116:53]),
        .in_sel     (s_tdata[117]),
        .res_status (res_status),
        .res_slot   (res_slot),
        .res_seq    (res_seq),
        .res_stamp  (res_stamp),
        .res_wire   (res_wire)
    );

    assign m_tdata = {2'b00, res_wire, res_stamp, res_seq, res_slot};
    assign m_tuser = res_status;

endmodule

`default_nettype wire
